FILE: src/fan_thermal_step_controller_macros.svh
// Assertion helpers for the controller top level.
`ifndef FAN_THERMAL_STEP_CONTROLLER_MACROS_SVH
`define FAN_THERMAL_STEP_CONTROLLER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define FTSC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define FTSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/ftsc_pkg.sv
package ftsc_pkg;

  localparam int unsigned TEMP_W    = 16;
  localparam int unsigned SPEED_W   = 8;
  localparam int unsigned DWELL_W   = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 16;

  localparam logic [SPEED_W-1:0] SPEED_ENTRY_AUTO = 8'd2;
  localparam logic [SPEED_W-1:0] SPEED_NONE       = 8'hFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEMP_HIGH   = 3'd0,
    CFG_TEMP_LOW    = 3'd1,
    CFG_TEMP_RISK   = 3'd2,
    CFG_TEMP_NORMAL = 3'd3,
    CFG_SPEED_MIN   = 3'd4,
    CFG_SPEED_MAX   = 3'd5,
    CFG_DWELL       = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temp_high;
    logic signed [TEMP_W-1:0] temp_low;
    logic signed [TEMP_W-1:0] temp_risk;
    logic signed [TEMP_W-1:0] temp_normal;
    logic [SPEED_W-1:0]       speed_min;
    logic [SPEED_W-1:0]       speed_max;
    logic [DWELL_W-1:0]       dwell_ticks;
  } cfg_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temperature;
    logic                     auto_enable;
    logic [SPEED_W-1:0]       manual_speed;
  } item_t;

  typedef struct packed {
    logic               drive_valid;
    logic [SPEED_W-1:0] drive_speed;
    logic               rescuing;
    logic               overheat;
  } result_t;

  // Controller state apart from the dwell counter, whose width is a parameter.
  typedef struct packed {
    logic               rescue_active;
    logic [SPEED_W-1:0] saved_speed;
    logic               prev_auto;
    logic [SPEED_W-1:0] auto_speed;
    logic               settling;
    logic [SPEED_W-1:0] manual_applied;
    logic [SPEED_W-1:0] driven_speed;
  } ctl_state_t;

endpackage

FILE: src/ftsc_channels.sv
interface ftsc_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [ftsc_pkg::TEMP_W-1:0]    temperature;
  logic                                  auto_enable;
  logic        [ftsc_pkg::SPEED_W-1:0]   manual_speed;

  modport source (output valid, temperature, auto_enable, manual_speed, input ready);
  modport sink   (input valid, temperature, auto_enable, manual_speed, output ready);
endinterface

interface ftsc_out_if;
  logic                                valid;
  logic                                ready;
  logic                                drive_valid;
  logic [ftsc_pkg::SPEED_W-1:0]        drive_speed;
  logic                                rescuing;
  logic                                overheat;

  modport source (output valid, drive_valid, drive_speed, rescuing, overheat, input ready);
  modport sink   (input valid, drive_valid, drive_speed, rescuing, overheat, output ready);
endinterface

interface ftsc_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [ftsc_pkg::CFG_IDX_W-1:0]       index;
  logic [ftsc_pkg::CFG_DAT_W-1:0]       data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: src/ftsc_cfg_regs.sv
module ftsc_cfg_regs (
  input  logic            clk,
  input  logic            rst_n,
  ftsc_cfg_if.sink        cfg_ch,
  output ftsc_pkg::cfg_t  cfg
);
  import ftsc_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ch.ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (cfg_idx_t'(cfg_ch.index))
        CFG_TEMP_HIGH:   cfg_nxt.temp_high   = $signed(cfg_ch.data);
        CFG_TEMP_LOW:    cfg_nxt.temp_low    = $signed(cfg_ch.data);
        CFG_TEMP_RISK:   cfg_nxt.temp_risk   = $signed(cfg_ch.data);
        CFG_TEMP_NORMAL: cfg_nxt.temp_normal = $signed(cfg_ch.data);
        CFG_SPEED_MIN:   cfg_nxt.speed_min   = cfg_ch.data[SPEED_W-1:0];
        CFG_SPEED_MAX:   cfg_nxt.speed_max   = cfg_ch.data[SPEED_W-1:0];
        CFG_DWELL:       cfg_nxt.dwell_ticks = cfg_ch.data[DWELL_W-1:0];
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.temp_high   <= 16'sd60;
      cfg_r.temp_low    <= 16'sd50;
      cfg_r.temp_risk   <= 16'sd80;
      cfg_r.temp_normal <= 16'sd70;
      cfg_r.speed_min   <= 8'd0;
      cfg_r.speed_max   <= 8'd10;
      cfg_r.dwell_ticks <= 16'd100;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

FILE: src/ftsc_tick_core.sv
module ftsc_tick_core #(
  parameter int unsigned CNT_W
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  ftsc_pkg::item_t   item,
  input  ftsc_pkg::cfg_t    cfg,
  output ftsc_pkg::result_t res
);
  import ftsc_pkg::*;

  ctl_state_t         st_r;
  ctl_state_t         st_nxt;
  logic [CNT_W-1:0]   cnt_r;
  logic [CNT_W-1:0]   cnt_nxt;
  logic [CNT_W-1:0]   cnt_inc;
  logic [31:0]        dwell_ext;
  logic [CNT_W-1:0]   dwell_m;
  logic               hot;
  logic               entry_auto;
  logic               entry_manual;
  logic [SPEED_W-1:0] step_spd;
  logic [SPEED_W-1:0] man_cur;

  assign dwell_ext = {{(32 - DWELL_W){1'b0}}, cfg.dwell_ticks};
  assign dwell_m   = dwell_ext[CNT_W-1:0];
  assign hot       = $signed(item.temperature) > $signed(cfg.temp_risk);

  always_comb begin
    st_nxt            = st_r;
    cnt_nxt           = cnt_r;
    cnt_inc           = '0;
    entry_auto        = 1'b0;
    entry_manual      = 1'b0;
    step_spd          = '0;
    man_cur           = '0;
    res.drive_valid   = 1'b0;
    res.drive_speed   = '0;

    // Overheat rescue takes precedence over both modes.
    if (hot) begin
      if (!st_r.rescue_active) begin
        st_nxt.saved_speed   = st_r.driven_speed;
        st_nxt.rescue_active = 1'b1;
        res.drive_valid      = 1'b1;
        res.drive_speed      = cfg.speed_max;
      end
    end else if (st_r.rescue_active &&
                 ($signed(item.temperature) < $signed(cfg.temp_normal))) begin
      res.drive_valid      = 1'b1;
      res.drive_speed      = st_r.saved_speed;
      st_nxt.rescue_active = 1'b0;
    end

    if (!st_nxt.rescue_active) begin
      entry_auto       = !st_r.prev_auto && item.auto_enable;
      entry_manual     = st_r.prev_auto && !item.auto_enable;
      st_nxt.prev_auto = item.auto_enable;
      if (item.auto_enable) begin
        if (entry_auto) begin
          st_nxt.auto_speed = SPEED_ENTRY_AUTO;
          st_nxt.settling   = 1'b0;
          cnt_nxt           = '0;
          res.drive_valid   = 1'b1;
          res.drive_speed   = SPEED_ENTRY_AUTO;
        end
        step_spd = st_nxt.auto_speed;
        if (st_nxt.settling) begin
          // Count the dwell; the tick that completes it does no step.
          cnt_inc = cnt_nxt + 1'b1;
          cnt_nxt = cnt_inc;
          if (cnt_inc == dwell_m) begin
            st_nxt.settling = 1'b0;
            cnt_nxt         = '0;
          end
        end else begin
          if ($signed(item.temperature) > $signed(cfg.temp_high)) begin
            if (step_spd < cfg.speed_max) begin
              step_spd        = step_spd + 1'b1;
              st_nxt.settling = 1'b1;
              cnt_nxt         = '0;
            end
          end else if ($signed(item.temperature) < $signed(cfg.temp_low)) begin
            if (step_spd > cfg.speed_min) begin
              step_spd        = step_spd - 1'b1;
              st_nxt.settling = 1'b1;
              cnt_nxt         = '0;
            end
          end
          if (step_spd != st_nxt.auto_speed) begin
            st_nxt.auto_speed = step_spd;
            res.drive_valid   = 1'b1;
            res.drive_speed   = step_spd;
          end
        end
      end else begin
        man_cur = entry_manual ? SPEED_NONE : st_r.manual_applied;
        if (man_cur != item.manual_speed) begin
          res.drive_valid = 1'b1;
          res.drive_speed = item.manual_speed;
          man_cur         = item.manual_speed;
        end
        st_nxt.manual_applied = man_cur;
      end
    end

    if (res.drive_valid) begin
      st_nxt.driven_speed = res.drive_speed;
    end
    res.rescuing = st_nxt.rescue_active;
    res.overheat = hot;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= '0;
      cnt_r <= '0;
    end else if (step_en) begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

FILE: src/fan_thermal_step_controller.sv
// Fan thermal step controller: one input item is one control tick and yields exactly one
// result item. An item is held in an input register and, in the cycle it moves to the
// result register, the tick decision (rescue check, auto step with dwell, manual follow)
// is made in one combinational pass on the controller state, which updates in the same
// cycle. A new item is taken every cycle while results are being taken; the result passes
// from the input register to the result register and is held there until taken. The
// configuration port is always ready; write it only while no item is in flight.
`include "fan_thermal_step_controller_macros.svh"

module fan_thermal_step_controller #(
  parameter int unsigned SETTLE_COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  ftsc_in_if.sink     in_ch,
  ftsc_out_if.source  out_ch,
  ftsc_cfg_if.sink    cfg_ch
);
  import ftsc_pkg::*;

  cfg_t    cfg;
  logic    in_vld_r;
  item_t   in_item_r;
  logic    out_vld_r;
  result_t res_r;
  result_t res_nxt;
  logic    advance;
  logic    step_en;

  ftsc_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  ftsc_tick_core #(
    .CNT_W (SETTLE_COUNT_BITS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .item    (in_item_r),
    .cfg     (cfg),
    .res     (res_nxt)
  );

  // Move the held item on whenever the result register is free or being emptied.
  assign advance     = !out_vld_r || out_ch.ready;
  assign step_en     = advance && in_vld_r;
  assign in_ch.ready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      in_vld_r <= 1'b1;
    end else if (advance) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_item_r.temperature  <= in_ch.temperature;
      in_item_r.auto_enable  <= in_ch.auto_enable;
      in_item_r.manual_speed <= in_ch.manual_speed;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.drive_valid = res_r.drive_valid;
  assign out_ch.drive_speed = res_r.drive_speed;
  assign out_ch.rescuing    = res_r.rescuing;
  assign out_ch.overheat    = res_r.overheat;

  `FTSC_ASSERT_NOW(a_overheat_rescues, out_vld_r && res_r.overheat, res_r.rescuing,
                   "overheat result without rescue")
  `FTSC_ASSERT_NOW(a_rescue_drive_max, out_vld_r && res_r.rescuing && res_r.drive_valid,
                   res_r.drive_speed == cfg.speed_max, "rescue start did not drive maximum speed")
  `FTSC_ASSERT_NOW(a_no_speed_idle, out_vld_r && !res_r.drive_valid, res_r.drive_speed == '0,
                   "speed shown without a command")
  `FTSC_ASSERT_NEXT(a_step_gives_result, step_en, out_vld_r, "processed item produced no result")

endmodule
